// ----- rtl/core/camera_dolly_along_view_core_assert.svh -----
// Assertion helpers for the camera dolly core.
`ifndef CAMERA_DOLLY_ALONG_VIEW_CORE_ASSERT_SVH
`define CAMERA_DOLLY_ALONG_VIEW_CORE_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define CDAV_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cdav assertion failed");

// Condition implies consequence in the next cycle.
`define CDAV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cdav assertion failed");

`endif

// ----- rtl/core/cdav_pkg.sv -----
`timescale 1ns / 1ps
package cdav_pkg;

    localparam int RSQRT_ITERATIONS = 4;
    localparam int ITER_W = $clog2(RSQRT_ITERATIONS + 1);

    localparam int COORD_W = 32;
    localparam int MAG_W   = 33;
    localparam int MUL_W   = 34;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int SUM_W   = 62;

    typedef logic [1:0] op_t;
    localparam op_t OP_LOAD_EYE    = 2'd0;
    localparam op_t OP_LOAD_TARGET = 2'd1;
    localparam op_t OP_MOVE        = 2'd2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [MAG_W-1:0] mag_t;

endpackage

// ----- rtl/core/camera_dolly_along_view_core.sv -----
`timescale 1ns / 1ps
// Camera dolly core: holds an eye point and a look-at point in signed Q16.16 and
// returns both points (plus zero_direction and saturated flags) once per transfer.
// A load (or the unused op code, which changes nothing) goes straight to the
// output state. A move runs on one shared 34x34 multiplier under a sequencer:
// the difference, one-bit normalizing shifts, the sum of squares and seed, the
// reciprocal square root steps (RSQRT_ITERATIONS steps), the scaled move for
// each axis in turn, and then the result is presented.
// in_stall stays high from acceptance until the result moves into the output
// register, which holds it while out_stall is high.
`include "camera_dolly_along_view_core_assert.svh"

module camera_dolly_along_view_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  cdav_pkg::op_t         op,
    input  cdav_pkg::coord_t      coord_x,
    input  cdav_pkg::coord_t      coord_y,
    input  cdav_pkg::coord_t      coord_z,
    input  cdav_pkg::coord_t      distance,
    output logic                  out_valid,
    input  logic                  out_stall,
    output cdav_pkg::coord_t      eye_x,
    output cdav_pkg::coord_t      eye_y,
    output cdav_pkg::coord_t      eye_z,
    output cdav_pkg::coord_t      target_x,
    output cdav_pkg::coord_t      target_y,
    output cdav_pkg::coord_t      target_z,
    output logic                  zero_direction,
    output logic                  saturated
);
    import cdav_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DIFF, ST_NORM, ST_SQ0, ST_SQ1, ST_SQ2, ST_SQ3, ST_SCALE,
        ST_SEED, ST_YY, ST_Y2, ST_XY, ST_HH, ST_YH, ST_YN, ST_MU, ST_UU,
        ST_DU, ST_ACC, ST_OUT
    } state_t;

    localparam mag_t         M_HI   = mag_t'(1) << 30;
    localparam mag_t         M_LO   = mag_t'(1) << 29;
    localparam logic [SUM_W-1:0] S_LO = SUM_W'(1) << 60;
    localparam logic [33:0]  THREE  = 34'd3 << 30;
    localparam logic [31:0]  SEED_C = 32'd9 << 28;
    localparam logic [30:0]  U_MAX  = 31'd1 << 30;

    state_t            state_reg, state_next;
    coord_t            eye_reg [3];
    coord_t            eye_next [3];
    coord_t            tgt_reg [3];
    coord_t            tgt_next [3];
    mag_t              mag_reg [3];
    mag_t              mag_next [3];
    logic [2:0]        neg_reg, neg_next;
    mag_t              m_reg, m_next;
    logic              dneg_reg, dneg_next;
    logic [31:0]       dmag_reg, dmag_next;
    logic [SUM_W-1:0]  s_reg, s_next;
    logic [31:0]       y_reg, y_next;
    logic [33:0]       y2_reg, y2_next;
    logic [31:0]       h_reg, h_next;
    logic [30:0]       u_reg, u_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic [1:0]        idx_reg, idx_next;
    logic              zdir_reg, zdir_next;
    logic              sat_reg, sat_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic              ov_reg, ov_next;
    coord_t            oe_reg [3];
    coord_t            oe_next [3];
    coord_t            ot_reg [3];
    coord_t            ot_next [3];
    logic              oz_reg, oz_next;
    logic              os_reg, os_next;

    logic [MUL_W-1:0]  mul_a, mul_b;
    logic              accept;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SQ0:
            begin
                mul_a = MUL_W'(mag_reg[0]);
                mul_b = MUL_W'(mag_reg[0]);
            end
            ST_SQ1:
            begin
                mul_a = MUL_W'(mag_reg[1]);
                mul_b = MUL_W'(mag_reg[1]);
            end
            ST_SQ2:
            begin
                mul_a = MUL_W'(mag_reg[2]);
                mul_b = MUL_W'(mag_reg[2]);
            end
            ST_YY:
            begin
                mul_a = MUL_W'(y_reg);
                mul_b = MUL_W'(y_reg);
            end
            ST_XY:
            begin
                mul_a = MUL_W'(s_reg[61:32]);
                mul_b = y2_reg;
            end
            ST_YH:
            begin
                mul_a = MUL_W'(y_reg);
                mul_b = MUL_W'(h_reg);
            end
            ST_MU:
            begin
                mul_a = MUL_W'(mag_reg[idx_reg]);
                mul_b = MUL_W'(y_reg);
            end
            ST_DU:
            begin
                mul_a = MUL_W'(dmag_reg);
                mul_b = MUL_W'(u_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        logic signed [MAG_W-1:0] d;
        mag_t                    mx;
        logic [33:0]             t;
        logic [32:0]             p;
        logic [31:0]             mv;
        logic [32:0]             delta;
        logic [33:0]             se, st;
        logic                    negd;

        state_next = state_reg;
        eye_next   = eye_reg;
        tgt_next   = tgt_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        m_next     = m_reg;
        dneg_next  = dneg_reg;
        dmag_next  = dmag_reg;
        s_next     = s_reg;
        y_next     = y_reg;
        y2_next    = y2_reg;
        h_next     = h_reg;
        u_next     = u_reg;
        iter_next  = iter_reg;
        idx_next   = idx_reg;
        zdir_next  = zdir_reg;
        sat_next   = sat_reg;
        ov_next    = ov_reg;
        oe_next    = oe_reg;
        ot_next    = ot_reg;
        oz_next    = oz_reg;
        os_next    = os_reg;
        prod_next  = PROD_W'(mul_a) * PROD_W'(mul_b);
        d     = '0;
        mx    = '0;
        t     = '0;
        p     = '0;
        mv    = '0;
        delta = '0;
        se    = '0;
        st    = '0;
        negd  = 1'b0;

        if (out_valid && !out_stall)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    zdir_next  = 1'b0;
                    sat_next   = 1'b0;
                    dneg_next  = distance[31];
                    dmag_next  = distance[31] ? 32'(-distance) : 32'(distance);
                    state_next = ST_OUT;
                    priority if (op == OP_LOAD_EYE)
                    begin
                        eye_next[0] = coord_x;
                        eye_next[1] = coord_y;
                        eye_next[2] = coord_z;
                    end
                    else if (op == OP_LOAD_TARGET)
                    begin
                        tgt_next[0] = coord_x;
                        tgt_next[1] = coord_y;
                        tgt_next[2] = coord_z;
                    end
                    else if (op == OP_MOVE)
                    begin
                        state_next = ST_DIFF;
                    end
                    else
                    begin
                        // unused code: keep both points, report them as they are
                        state_next = ST_OUT;
                    end
                end
            end
            ST_DIFF:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    d = $signed({tgt_reg[i][31], tgt_reg[i]})
                        - $signed({eye_reg[i][31], eye_reg[i]});
                    neg_next[i] = d[MAG_W-1];
                    mag_next[i] = d[MAG_W-1] ? mag_t'(-d) : mag_t'(d);
                    if (mag_next[i] > mx)
                    begin
                        mx = mag_next[i];
                    end
                end
                m_next = mx;
                if (mx == '0)
                begin
                    zdir_next  = 1'b1;
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                // one bit per cycle until the largest lies in [2^29, 2^30)
                priority if (m_reg >= M_HI)
                begin
                    m_next = m_reg >> 1;
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_next[i] = mag_reg[i] >> 1;
                    end
                end
                else if (m_reg < M_LO)
                begin
                    m_next = m_reg << 1;
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_next[i] = mag_reg[i] << 1;
                    end
                end
                else
                begin
                    state_next = ST_SQ0;
                end
            end
            ST_SQ0:
            begin
                state_next = ST_SQ1;
            end
            ST_SQ1:
            begin
                s_next     = prod_reg[SUM_W-1:0];
                state_next = ST_SQ2;
            end
            ST_SQ2:
            begin
                s_next     = s_reg + prod_reg[SUM_W-1:0];
                state_next = ST_SQ3;
            end
            ST_SQ3:
            begin
                s_next     = s_reg + prod_reg[SUM_W-1:0];
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                if (s_reg < S_LO)
                begin
                    s_next = s_reg << 2;
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_next[i] = mag_reg[i] << 1;
                    end
                end
                state_next = ST_SEED;
            end
            ST_SEED:
            begin
                // 5x needs 33 bits before the shift
                y_next = SEED_C - 32'(({3'b000, s_reg[61:32]}
                         + {1'b0, s_reg[61:32], 2'b00}) >> 2);
                iter_next  = '0;
                state_next = (RSQRT_ITERATIONS == 0) ? ST_MU : ST_YY;
                idx_next   = '0;
            end
            ST_YY:
            begin
                state_next = ST_Y2;
            end
            ST_Y2:
            begin
                y2_next    = prod_reg[63:30];
                state_next = ST_XY;
            end
            ST_XY:
            begin
                state_next = ST_HH;
            end
            ST_HH:
            begin
                t          = prod_reg[63:30];
                h_next     = (t < THREE) ? 32'(THREE - t) : 32'd0;
                state_next = ST_YH;
            end
            ST_YH:
            begin
                state_next = ST_YN;
            end
            ST_YN:
            begin
                p         = prod_reg[63:31];
                y_next    = p[32] ? 32'hFFFF_FFFF : p[31:0];
                iter_next = iter_reg + 1'b1;
                if (iter_next == ITER_W'(RSQRT_ITERATIONS))
                begin
                    idx_next   = '0;
                    state_next = ST_MU;
                end
                else
                begin
                    state_next = ST_YY;
                end
            end
            ST_MU:
            begin
                state_next = ST_UU;
            end
            ST_UU:
            begin
                u_next = (prod_reg[PROD_W-1:31] > (PROD_W-31)'(U_MAX))
                         ? U_MAX : prod_reg[61:31];
                state_next = ST_DU;
            end
            ST_DU:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                mv    = prod_reg[61:30];
                negd  = neg_reg[idx_reg] ^ dneg_reg;
                delta = negd ? -{1'b0, mv} : {1'b0, mv};
                se = {{2{eye_reg[idx_reg][31]}}, eye_reg[idx_reg]}
                     + {delta[32], delta};
                st = {{2{tgt_reg[idx_reg][31]}}, tgt_reg[idx_reg]}
                     + {delta[32], delta};
                if (se[33:31] != 3'b000 && se[33:31] != 3'b111)
                begin
                    sat_next = 1'b1;
                    eye_next[idx_reg] = se[33] ? coord_t'(32'h8000_0000)
                                               : coord_t'(32'h7FFF_FFFF);
                end
                else
                begin
                    eye_next[idx_reg] = coord_t'(se[31:0]);
                end
                if (st[33:31] != 3'b000 && st[33:31] != 3'b111)
                begin
                    sat_next = 1'b1;
                    tgt_next[idx_reg] = st[33] ? coord_t'(32'h8000_0000)
                                               : coord_t'(32'h7FFF_FFFF);
                end
                else
                begin
                    tgt_next[idx_reg] = coord_t'(st[31:0]);
                end
                idx_next   = idx_reg + 1'b1;
                state_next = (idx_reg == 2'd2) ? ST_OUT : ST_MU;
            end
            ST_OUT:
            begin
                // hold until the output register is free
                if (!out_valid || !out_stall)
                begin
                    ov_next    = 1'b1;
                    oe_next    = eye_reg;
                    ot_next    = tgt_reg;
                    oz_next    = zdir_reg;
                    os_next    = sat_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < 3; i++)
            begin
                eye_reg[i] <= '0;
                tgt_reg[i] <= '0;
                mag_reg[i] <= '0;
                oe_reg[i]  <= '0;
                ot_reg[i]  <= '0;
            end
            neg_reg  <= '0;
            m_reg    <= '0;
            dneg_reg <= 1'b0;
            dmag_reg <= '0;
            s_reg    <= '0;
            y_reg    <= '0;
            y2_reg   <= '0;
            h_reg    <= '0;
            u_reg    <= '0;
            iter_reg <= '0;
            idx_reg  <= '0;
            zdir_reg <= 1'b0;
            sat_reg  <= 1'b0;
            prod_reg <= '0;
            ov_reg   <= 1'b0;
            oz_reg   <= 1'b0;
            os_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            eye_reg   <= eye_next;
            tgt_reg   <= tgt_next;
            mag_reg   <= mag_next;
            oe_reg    <= oe_next;
            ot_reg    <= ot_next;
            neg_reg   <= neg_next;
            m_reg     <= m_next;
            dneg_reg  <= dneg_next;
            dmag_reg  <= dmag_next;
            s_reg     <= s_next;
            y_reg     <= y_next;
            y2_reg    <= y2_next;
            h_reg     <= h_next;
            u_reg     <= u_next;
            iter_reg  <= iter_next;
            idx_reg   <= idx_next;
            zdir_reg  <= zdir_next;
            sat_reg   <= sat_next;
            prod_reg  <= prod_next;
            ov_reg    <= ov_next;
            oz_reg    <= oz_next;
            os_reg    <= os_next;
        end
    end

    assign out_valid      = ov_reg;
    assign eye_x          = oe_reg[0];
    assign eye_y          = oe_reg[1];
    assign eye_z          = oe_reg[2];
    assign target_x       = ot_reg[0];
    assign target_y       = ot_reg[1];
    assign target_z       = ot_reg[2];
    assign zero_direction = oz_reg;
    assign saturated      = os_reg;

    `CDAV_ASSERT_SAME(a_flags_excl, clk, rst_n, out_valid, !(zero_direction && saturated))
    `CDAV_ASSERT_SAME(a_iter_bound, clk, rst_n, 1'b1,
        iter_reg <= ITER_W'(RSQRT_ITERATIONS))
    `CDAV_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, state_reg != ST_IDLE)
    `CDAV_ASSERT_SAME(a_norm_range, clk, rst_n, state_reg == ST_SQ0,
        m_reg >= M_LO && m_reg < M_HI)
    `CDAV_ASSERT_SAME(a_unit_bound, clk, rst_n, 1'b1, u_reg <= U_MAX)

endmodule

// ----- dv/camera_dolly_along_view_core_test.sv -----
`timescale 1ns / 1ps
module camera_dolly_along_view_core_test;
    import cdav_pkg::*;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   in_valid = 1'b0;
    logic   in_stall;
    op_t    op = OP_LOAD_EYE;
    coord_t coord_x = '0;
    coord_t coord_y = '0;
    coord_t coord_z = '0;
    coord_t distance = '0;
    logic   out_valid;
    logic   out_stall = 1'b0;
    coord_t eye_x, eye_y, eye_z, target_x, target_y, target_z;
    logic   zero_direction, saturated;

    localparam op_t OP_UNUSED = 2'd3;
    localparam int  DRAIN_CYCLES = 200;

    typedef struct packed {
        coord_t ex, ey, ez, tx, ty, tz;
        logic   zdir, sat;
    } camera_state_t;

    camera_state_t pending_states[$];
    coord_t        eye_model[3];
    coord_t        target_model[3];
    int            mismatch_count = 0;
    int            result_count = 0;
    int            move_count = 0;
    int            sat_count = 0;
    int            zero_count = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            hold_cycles = 0;

    camera_dolly_along_view_core u_top (.*);

    always #4 clk = ~clk;

    function automatic logic [63:0] rsqrt_q30(logic [63:0] x30);
        logic [63:0] y, y2, t, h;
        y = (64'd9 << 28) - ((64'd5 * x30) >> 2);
        for (int i = 0; i < RSQRT_ITERATIONS; i++)
        begin
            y2 = (y * y) >> 30;
            t = (x30 * y2) >> 30;
            h = (t < (64'd3 << 30)) ? (64'd3 << 30) - t : 64'd0;
            y = (y * h) >> 31;
            if (y > 64'hFFFF_FFFF)
                y = 64'hFFFF_FFFF;
        end
        return y;
    endfunction

    function automatic coord_t clamp_add(coord_t base, longint delta, inout logic sat);
        longint s;
        s = longint'(base) + delta;
        if (s > 64'sd2147483647)
        begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (s < -64'sd2147483648)
        begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return coord_t'(s);
    endfunction

    // Update the camera model with one item and return the expected result.
    function automatic camera_state_t dolly_step(op_t o, coord_t cx, coord_t cy,
                                                 coord_t cz, coord_t move_dist);
        camera_state_t r;
        logic [63:0]   mag[3];
        logic [63:0]   m, s, y, u, mv, dmag;
        logic          neg[3];
        logic          dneg;
        longint        d, delta;
        r = '0;
        if (o == OP_LOAD_EYE)
        begin
            eye_model[0] = cx; eye_model[1] = cy; eye_model[2] = cz;
        end
        else if (o == OP_LOAD_TARGET)
        begin
            target_model[0] = cx; target_model[1] = cy; target_model[2] = cz;
        end
        else if (o == OP_MOVE)
        begin
            m = 0;
            for (int i = 0; i < 3; i++)
            begin
                d = longint'(target_model[i]) - longint'(eye_model[i]);
                neg[i] = d < 0;
                mag[i] = neg[i] ? -d : d;
                if (mag[i] > m)
                    m = mag[i];
            end
            if (m == 0)
                r.zdir = 1'b1;
            else
            begin
                dneg = move_dist < 0;
                dmag = dneg ? -longint'(move_dist) : longint'(move_dist);
                while (m >= (64'd1 << 30))
                begin
                    m >>= 1;
                    for (int i = 0; i < 3; i++) mag[i] >>= 1;
                end
                while (m < (64'd1 << 29))
                begin
                    m <<= 1;
                    for (int i = 0; i < 3; i++) mag[i] <<= 1;
                end
                s = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
                if (s < (64'd1 << 60))
                begin
                    s <<= 2;
                    for (int i = 0; i < 3; i++) mag[i] <<= 1;
                end
                y = rsqrt_q30(s >> 32);
                for (int i = 0; i < 3; i++)
                begin
                    u = (mag[i] * y) >> 31;
                    if (u > (64'd1 << 30))
                        u = 64'd1 << 30;
                    mv = (dmag * u) >> 30;
                    delta = (neg[i] != dneg) ? -longint'(mv) : longint'(mv);
                    eye_model[i] = clamp_add(eye_model[i], delta, r.sat);
                    target_model[i] = clamp_add(target_model[i], delta, r.sat);
                end
            end
        end
        r.ex = eye_model[0]; r.ey = eye_model[1]; r.ez = eye_model[2];
        r.tx = target_model[0]; r.ty = target_model[1]; r.tz = target_model[2];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("result %0d: %s got %h, want %h", result_count, what, got, want);
        mismatch_count++;
    endtask

    // Offer one transfer, idling beforehand at the current sender rate.
    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(op_t o, coord_t cx, coord_t cy, coord_t cz, coord_t move_dist);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        op <= o; coord_x <= cx; coord_y <= cy; coord_z <= cz; distance <= move_dist;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_states.push_back(dolly_step(o, cx, cy, cz, move_dist));
        if (o == OP_MOVE)
            move_count++;
        @(negedge clk);
    endtask

    // Drop valid, then wait for every expected result.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_states.size() != 0)
            @(negedge clk);
    endtask

    function automatic coord_t rand_coord();
        case ($urandom_range(5))
            0: return coord_t'($urandom_range(4095)) - 2048;
            1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return coord_t'($urandom_range(32'h0020_0000)) - 32'h0010_0000;
            default: return $urandom;
        endcase
    endfunction

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        camera_state_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            result_count++;
            if (pending_states.size() == 0)
            begin
                $display("result %0d: no result expected", result_count);
                mismatch_count++;
            end
            else
            begin
                want = pending_states.pop_front();
                if (eye_x !== want.ex) report_mismatch("eye_x", eye_x, want.ex);
                if (eye_y !== want.ey) report_mismatch("eye_y", eye_y, want.ey);
                if (eye_z !== want.ez) report_mismatch("eye_z", eye_z, want.ez);
                if (target_x !== want.tx) report_mismatch("target_x", target_x, want.tx);
                if (target_y !== want.ty) report_mismatch("target_y", target_y, want.ty);
                if (target_z !== want.tz) report_mismatch("target_z", target_z, want.tz);
                if (zero_direction !== want.zdir)
                    report_mismatch("zero_direction", zero_direction, want.zdir);
                if (saturated !== want.sat)
                    report_mismatch("saturated", saturated, want.sat);
                if (want.sat) sat_count++;
                if (want.zdir) zero_count++;
            end
        end
    end

    task automatic test_directed();
        send_item(OP_MOVE, 0, 0, 0, 32'h0001_0000);
        send_item(OP_UNUSED, 32'h1234_5678, -1, 5, 7);
        send_item(OP_LOAD_TARGET, 32'h0001_0000, 0, 0, 0);
        send_item(OP_MOVE, 0, 0, 0, 32'h0002_0000);
        send_item(OP_MOVE, 0, 0, 0, 32'hFFFF_0000);
        send_item(OP_LOAD_EYE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        send_item(OP_LOAD_TARGET, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_item(OP_MOVE, 0, 0, 0, 32'h7FFF_FFFF);
        send_item(OP_MOVE, 0, 0, 0, 32'h8000_0000);
        send_item(OP_LOAD_EYE, 0, 0, 0, -1);
        send_item(OP_LOAD_TARGET, 0, 0, 1, 0);
        send_item(OP_MOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
        send_item(OP_LOAD_TARGET, 3, -7, 2, 0);
        send_item(OP_MOVE, 0, 0, 0, 32'h0100_0000);
        send_item(OP_LOAD_EYE, 32'h7FFF_FFFF, 0, 32'h8000_0000, 0);
        send_item(OP_LOAD_TARGET, 32'h7FFF_FFFF, 0, 32'h8000_0000, 0);
        send_item(OP_MOVE, 0, 0, 0, 32'h0001_0000);
        send_item(OP_MOVE, 0, 0, 0, 32'h5555_AAAA);
    endtask

    task automatic test_random(int count);
        int  pick;
        op_t o;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            o = (pick < 50) ? OP_MOVE : (pick < 72) ? OP_LOAD_EYE :
                (pick < 95) ? OP_LOAD_TARGET : OP_UNUSED;
            send_item(o, rand_coord(), rand_coord(), rand_coord(), rand_coord());
        end
    endtask

    // Hold off the receiver while the sender keeps pushing transfers.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 400;
        test_random(12);
        wait_drained();
    endtask

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        wait_drained();
        test_backpressure();
        send_idle_pct = 0;  recv_stall_pct = 0;  test_random(380);
        send_idle_pct = 68; recv_stall_pct = 0;  test_random(380);
        wait_drained();
        send_idle_pct = 0;  recv_stall_pct = 68; test_random(380);
        send_idle_pct = 8;  recv_stall_pct = 8;  test_random(380);
        wait_drained();
        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Checked %0d results: %0d moves, %0d saturated, %0d zero-direction.",
                 result_count, move_count, sat_count, zero_count);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
